@@ design/bfm_pkg.sv @@
// Package for the button fan mode controller.
// Holds the state, configuration and result types and the reset constants.
// No dependencies.
package bfm_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_PRESS_UNIT_TICKS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS_UNITS = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_ON_TICKS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LONG_OFF_TICKS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_ON_TICKS = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_OFF_TICKS = 3'd5;

  localparam logic [15:0] RST_PRESS_UNIT_TICKS = 16'd100;
  localparam logic [7:0] RST_LONG_PRESS_UNITS = 8'd15;
  localparam logic [15:0] RST_LONG_ON_TICKS = 16'd2000;
  localparam logic [15:0] RST_LONG_OFF_TICKS = 16'd10;
  localparam logic [15:0] RST_SHORT_ON_TICKS = 16'd300;
  localparam logic [15:0] RST_SHORT_OFF_TICKS = 16'd100;

  localparam logic [2:0] MODE_STANDBY = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_LOW = 3'd2;
  localparam logic [2:0] MODE_MID = 3'd3;
  localparam logic [2:0] MODE_HIGH = 3'd4;

  localparam logic [6:0] DUTY_OFF = 7'd0;
  localparam logic [6:0] DUTY_LOW = 7'd49;
  localparam logic [6:0] DUTY_MID = 7'd79;
  localparam logic [6:0] DUTY_HIGH = 7'd100;

  localparam logic [7:0] UNITS_MAX = 8'd255;

  typedef struct packed {
    logic [15:0] press_unit_ticks;
    logic [7:0]  long_press_units;
    logic [15:0] long_on_ticks;
    logic [15:0] long_off_ticks;
    logic [15:0] short_on_ticks;
    logic [15:0] short_off_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  press_units;
    logic [15:0] press_sub;
    logic [1:0]  beeps_left;
    logic        beep_long;
    logic        beep_on;
    logic [15:0] beep_timer;
    logic [6:0]  duty;
  } state_t;

  typedef struct packed {
    logic [2:0] fan_mode;
    logic [6:0] fan_compare;
    logic       green_led;
    logic       buzzer_on;
    logic       charge_led;
    logic       beeping;
  } result_t;

endpackage

@@ design/bfm_if.sv @@
// Channel interfaces for the button fan mode controller: input ticks,
// results and configuration writes. Depends on bfm_pkg.
interface bfm_in_if;
  logic valid;
  logic ready;
  logic switch_pressed;
  logic vbus_present;
  logic charge_status_pin;
  modport source (output valid, switch_pressed, vbus_present, charge_status_pin, input ready);
  modport sink (input valid, switch_pressed, vbus_present, charge_status_pin, output ready);
endinterface

interface bfm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] fan_mode;
  logic [6:0] fan_compare;
  logic       green_led;
  logic       buzzer_on;
  logic       charge_led;
  logic       beeping;
  modport source (output valid, fan_mode, fan_compare, green_led, buzzer_on, charge_led,
                  beeping, input ready);
  modport sink (input valid, fan_mode, fan_compare, green_led, buzzer_on, charge_led,
                beeping, output ready);
endinterface

interface bfm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bfm_pkg::CfgIdxW-1:0]  index;
  logic [bfm_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/bfm_step.sv @@
// Next-state and result logic for one tick: press measurement, mode change
// and beep sequencing. Depends on bfm_pkg.
module bfm_step (
  input  bfm_pkg::state_t  st,
  input  bfm_pkg::cfg_t    cfg,
  input  logic             switch_pressed,
  input  logic             vbus_present,
  input  logic             charge_status_pin,
  output bfm_pkg::state_t  st_nxt,
  output bfm_pkg::result_t res
);

  function automatic bfm_pkg::state_t enter_mode(bfm_pkg::state_t s, logic [2:0] m,
                                                 logic [15:0] lon, logic [15:0] son);
    bfm_pkg::state_t r;
    r = s;
    r.mode = m;
    case (m)
      bfm_pkg::MODE_STANDBY: begin
        r.duty = bfm_pkg::DUTY_OFF; r.beeps_left = 2'd1; r.beep_long = 1'b1;
      end
      bfm_pkg::MODE_START: begin
        r.beeps_left = 2'd1; r.beep_long = 1'b1;
      end
      bfm_pkg::MODE_LOW: begin
        r.duty = bfm_pkg::DUTY_LOW; r.beeps_left = 2'd1; r.beep_long = 1'b0;
      end
      bfm_pkg::MODE_MID: begin
        r.duty = bfm_pkg::DUTY_MID; r.beeps_left = 2'd2; r.beep_long = 1'b0;
      end
      bfm_pkg::MODE_HIGH: begin
        r.duty = bfm_pkg::DUTY_HIGH; r.beeps_left = 2'd3; r.beep_long = 1'b0;
      end
      default: begin
        r.duty = bfm_pkg::DUTY_OFF; r.beeps_left = 2'd0; r.beep_long = 1'b0;
      end
    endcase
    r.beep_on = (r.beeps_left != 2'd0);
    if (r.beeps_left == 2'd0) r.beep_timer = 16'd0;
    else r.beep_timer = r.beep_long ? lon : son;
    return r;
  endfunction

  bfm_pkg::state_t s;
  logic [16:0]     sub_inc;
  logic [2:0]      next_mode;
  logic            buzz;
  logic            active;

  always_comb begin
    s = st;
    buzz = 1'b0;
    active = 1'b0;
    sub_inc = {1'b0, st.press_sub} + 17'd1;
    next_mode = bfm_pkg::MODE_STANDBY;

    if (s.beeps_left == 2'd0) begin
      if (switch_pressed) begin
        if (s.press_sub == 16'd0 && s.press_units != bfm_pkg::UNITS_MAX) begin
          s.press_units = s.press_units + 8'd1;
        end
        if (sub_inc >= {1'b0, cfg.press_unit_ticks}) s.press_sub = 16'd0;
        else s.press_sub = sub_inc[15:0];
      end else if (s.press_units != 8'd0) begin
        if (s.press_units >= cfg.long_press_units) begin
          next_mode = (s.mode == bfm_pkg::MODE_STANDBY) ? bfm_pkg::MODE_START
                                                        : bfm_pkg::MODE_STANDBY;
        end else if (s.mode >= bfm_pkg::MODE_HIGH) begin
          next_mode = bfm_pkg::MODE_LOW;
        end else begin
          next_mode = s.mode + 3'd1;
        end
        s.press_units = 8'd0;
        s.press_sub = 16'd0;
        s = enter_mode(s, next_mode, cfg.long_on_ticks, cfg.short_on_ticks);
      end
    end

    if (s.beeps_left != 2'd0) begin
      active = 1'b1;
      buzz = s.beep_on;
      if (s.beep_timer <= 16'd1) begin
        if (s.beep_on) begin
          s.beep_on = 1'b0;
          s.beep_timer = s.beep_long ? cfg.long_off_ticks : cfg.short_off_ticks;
        end else begin
          s.beeps_left = s.beeps_left - 2'd1;
          if (s.beeps_left != 2'd0) begin
            s.beep_on = 1'b1;
            s.beep_timer = s.beep_long ? cfg.long_on_ticks : cfg.short_on_ticks;
          end else begin
            s.beep_timer = 16'd0;
            if (s.mode == bfm_pkg::MODE_START) begin
              s = enter_mode(s, bfm_pkg::MODE_LOW, cfg.long_on_ticks, cfg.short_on_ticks);
            end
          end
        end
      end else begin
        s.beep_timer = s.beep_timer - 16'd1;
      end
    end

    st_nxt = s;
    res.fan_mode = s.mode;
    res.fan_compare = s.duty;
    res.green_led = (s.mode >= bfm_pkg::MODE_START) && (s.mode <= bfm_pkg::MODE_HIGH);
    res.buzzer_on = buzz;
    res.charge_led = vbus_present && !charge_status_pin;
    res.beeping = active;
  end

endmodule

@@ design/button_fan_mode_controller.sv @@
// Button fan mode controller top level: configuration registers, state
// registers and result register around bfm_step. Depends on bfm_pkg, bfm_if.
// Latency: a result is valid on the cycle after its tick transfer.
// Throughput: one tick per cycle while each result is taken; the whole state update is combinational.
// The result register frees as it is taken, so a new tick is accepted alongside.
// Reset (rst_n low, synchronous): standby, no beeps, configuration registers to defaults.
module button_fan_mode_controller (
  input logic       clk,
  input logic       rst_n,
  bfm_in_if.sink    in_ch,
  bfm_out_if.source out_ch,
  bfm_cfg_if.sink   cfg_ch
);

  bfm_pkg::cfg_t    cfg_r;
  bfm_pkg::state_t  st_r;
  bfm_pkg::state_t  st_nxt;
  bfm_pkg::result_t res_nxt;
  bfm_pkg::result_t res_r;
  logic             out_valid_r;
  logic             in_xfer;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer = in_ch.valid && in_ch.ready;

  bfm_step u_step (
    .st                (st_r),
    .cfg               (cfg_r),
    .switch_pressed    (in_ch.switch_pressed),
    .vbus_present      (in_ch.vbus_present),
    .charge_status_pin (in_ch.charge_status_pin),
    .st_nxt            (st_nxt),
    .res               (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_unit_ticks <= bfm_pkg::RST_PRESS_UNIT_TICKS;
      cfg_r.long_press_units <= bfm_pkg::RST_LONG_PRESS_UNITS;
      cfg_r.long_on_ticks <= bfm_pkg::RST_LONG_ON_TICKS;
      cfg_r.long_off_ticks <= bfm_pkg::RST_LONG_OFF_TICKS;
      cfg_r.short_on_ticks <= bfm_pkg::RST_SHORT_ON_TICKS;
      cfg_r.short_off_ticks <= bfm_pkg::RST_SHORT_OFF_TICKS;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bfm_pkg::CFG_PRESS_UNIT_TICKS: cfg_r.press_unit_ticks <= cfg_ch.data;
        bfm_pkg::CFG_LONG_PRESS_UNITS: cfg_r.long_press_units <= cfg_ch.data[7:0];
        bfm_pkg::CFG_LONG_ON_TICKS: cfg_r.long_on_ticks <= cfg_ch.data;
        bfm_pkg::CFG_LONG_OFF_TICKS: cfg_r.long_off_ticks <= cfg_ch.data;
        bfm_pkg::CFG_SHORT_ON_TICKS: cfg_r.short_on_ticks <= cfg_ch.data;
        bfm_pkg::CFG_SHORT_OFF_TICKS: cfg_r.short_off_ticks <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        st_r <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) res_r <= res_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.fan_mode = res_r.fan_mode;
  assign out_ch.fan_compare = res_r.fan_compare;
  assign out_ch.green_led = res_r.green_led;
  assign out_ch.buzzer_on = res_r.buzzer_on;
  assign out_ch.charge_led = res_r.charge_led;
  assign out_ch.beeping = res_r.beeping;

  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("tick transfer without a result");

  a_mode_reachable: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode <= bfm_pkg::MODE_HIGH)
    else $error("mode out of range");

  a_buzz_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.buzzer_on |-> res_r.beeping)
    else $error("buzzer on outside a beep sequence");

  a_duty_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.fan_mode == bfm_pkg::MODE_MID |->
      res_r.fan_compare == bfm_pkg::DUTY_MID)
    else $error("compare value does not match mode");

  a_led_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.green_led == (res_r.fan_mode != bfm_pkg::MODE_STANDBY))
    else $error("green LED does not match mode");

endmodule

@@ sim/fan_mode_checker.sv @@
// Result checker for the button fan mode controller: watches the tick, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on bfm_pkg and bfm_if.
module fan_mode_checker (
  input  logic        clk,
  input  logic        rst_n,
  bfm_in_if           in_mon,
  bfm_out_if          out_mon,
  bfm_cfg_if          cfg_mon,
  output int unsigned mismatches,
  output int unsigned due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  bfm_pkg::cfg_t    settings;
  bfm_pkg::state_t  fan;
  bfm_pkg::result_t results_due[$];
  bfm_pkg::result_t want;
  int unsigned      result_no;

  initial begin
    mismatches = 0;
    due_count  = 0;
    result_no  = 0;
  end

  task automatic report(input string msg);
    $display("ERROR result %0d at %0t: %s", result_no, $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [6:0] got, input logic [6:0] exp_val);
    if (got !== exp_val) begin
      report($sformatf("%s is %0d, expected %0d", name, got, exp_val));
    end
  endtask

  function automatic void set_mode(input logic [2:0] m);
    fan.mode = m;
    case (m)
      bfm_pkg::MODE_STANDBY: begin
        fan.duty       = bfm_pkg::DUTY_OFF;
        fan.beeps_left = 2'd1;
        fan.beep_long  = 1'b1;
      end
      bfm_pkg::MODE_START: begin
        fan.beeps_left = 2'd1;
        fan.beep_long  = 1'b1;
      end
      bfm_pkg::MODE_LOW: begin
        fan.duty       = bfm_pkg::DUTY_LOW;
        fan.beeps_left = 2'd1;
        fan.beep_long  = 1'b0;
      end
      bfm_pkg::MODE_MID: begin
        fan.duty       = bfm_pkg::DUTY_MID;
        fan.beeps_left = 2'd2;
        fan.beep_long  = 1'b0;
      end
      bfm_pkg::MODE_HIGH: begin
        fan.duty       = bfm_pkg::DUTY_HIGH;
        fan.beeps_left = 2'd3;
        fan.beep_long  = 1'b0;
      end
      default: begin
        fan.duty       = bfm_pkg::DUTY_OFF;
        fan.beeps_left = 2'd0;
        fan.beep_long  = 1'b0;
      end
    endcase
    fan.beep_on = (fan.beeps_left != 2'd0);
    if (fan.beeps_left == 2'd0) begin
      fan.beep_timer = 16'd0;
    end else begin
      fan.beep_timer = fan.beep_long ? settings.long_on_ticks : settings.short_on_ticks;
    end
  endfunction

  function automatic bfm_pkg::result_t fan_tick(input logic pressed, input logic vbus,
                                                input logic chg);
    bfm_pkg::result_t r;
    logic [2:0]       next_mode;
    logic [16:0]      sub_next;
    logic             buzz;
    logic             active;
    buzz   = 1'b0;
    active = 1'b0;
    if (fan.beeps_left == 2'd0) begin
      if (pressed) begin
        if (fan.press_sub == 16'd0 && fan.press_units != bfm_pkg::UNITS_MAX) begin
          fan.press_units++;
        end
        sub_next      = {1'b0, fan.press_sub} + 17'd1;
        fan.press_sub = (sub_next >= {1'b0, settings.press_unit_ticks}) ? 16'd0 : sub_next[15:0];
      end else if (fan.press_units != 8'd0) begin
        if (fan.press_units >= settings.long_press_units) begin
          next_mode = (fan.mode == bfm_pkg::MODE_STANDBY) ? bfm_pkg::MODE_START
                                                          : bfm_pkg::MODE_STANDBY;
        end else begin
          next_mode = (fan.mode >= bfm_pkg::MODE_HIGH) ? bfm_pkg::MODE_LOW : fan.mode + 3'd1;
        end
        fan.press_units = 8'd0;
        fan.press_sub   = 16'd0;
        set_mode(next_mode);
      end
    end
    if (fan.beeps_left != 2'd0) begin
      active = 1'b1;
      buzz   = fan.beep_on;
      if (fan.beep_timer <= 16'd1) begin
        if (fan.beep_on) begin
          fan.beep_on    = 1'b0;
          fan.beep_timer = fan.beep_long ? settings.long_off_ticks : settings.short_off_ticks;
        end else begin
          fan.beeps_left = fan.beeps_left - 2'd1;
          if (fan.beeps_left != 2'd0) begin
            fan.beep_on    = 1'b1;
            fan.beep_timer = fan.beep_long ? settings.long_on_ticks : settings.short_on_ticks;
          end else begin
            fan.beep_timer = 16'd0;
            if (fan.mode == bfm_pkg::MODE_START) begin
              set_mode(bfm_pkg::MODE_LOW);
            end
          end
        end
      end else begin
        fan.beep_timer--;
      end
    end
    r.fan_mode    = fan.mode;
    r.fan_compare = fan.duty;
    r.green_led   = (fan.mode >= bfm_pkg::MODE_START && fan.mode <= bfm_pkg::MODE_HIGH);
    r.buzzer_on   = buzz;
    r.charge_led  = vbus && !chg;
    r.beeping     = active;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      settings.press_unit_ticks = bfm_pkg::RST_PRESS_UNIT_TICKS;
      settings.long_press_units = bfm_pkg::RST_LONG_PRESS_UNITS;
      settings.long_on_ticks    = bfm_pkg::RST_LONG_ON_TICKS;
      settings.long_off_ticks   = bfm_pkg::RST_LONG_OFF_TICKS;
      settings.short_on_ticks   = bfm_pkg::RST_SHORT_ON_TICKS;
      settings.short_off_ticks  = bfm_pkg::RST_SHORT_OFF_TICKS;
      fan = '0;
      results_due.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        result_no++;
        if (results_due.size() == 0) begin
          report("result transfer with no tick outstanding");
        end else begin
          want = results_due.pop_front();
          check_field("fan_mode", 7'(out_mon.fan_mode), 7'(want.fan_mode));
          check_field("fan_compare", out_mon.fan_compare, want.fan_compare);
          check_field("green_led", 7'(out_mon.green_led), 7'(want.green_led));
          check_field("buzzer_on", 7'(out_mon.buzzer_on), 7'(want.buzzer_on));
          check_field("charge_led", 7'(out_mon.charge_led), 7'(want.charge_led));
          check_field("beeping", 7'(out_mon.beeping), 7'(want.beeping));
        end
      end
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        case (cfg_mon.index)
          bfm_pkg::CFG_PRESS_UNIT_TICKS: settings.press_unit_ticks = cfg_mon.data;
          bfm_pkg::CFG_LONG_PRESS_UNITS: settings.long_press_units = cfg_mon.data[7:0];
          bfm_pkg::CFG_LONG_ON_TICKS:    settings.long_on_ticks    = cfg_mon.data;
          bfm_pkg::CFG_LONG_OFF_TICKS:   settings.long_off_ticks   = cfg_mon.data;
          bfm_pkg::CFG_SHORT_ON_TICKS:   settings.short_on_ticks   = cfg_mon.data;
          bfm_pkg::CFG_SHORT_OFF_TICKS:  settings.short_off_ticks  = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        results_due.push_back(fan_tick(in_mon.switch_pressed, in_mon.vbus_present,
                                       in_mon.charge_status_pin));
      end
    end
    due_count = results_due.size();
  end

endmodule

@@ sim/testbench.sv @@
// Top of the fan mode controller bench: clock, reset, tick and configuration
// stimulus, result receiver and verdict. Depends on bfm_pkg, bfm_if,
// fan_mode_checker and button_fan_mode_controller.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RECEIVER_HOLD = 150;

  logic        clk = 1'b0;
  logic        rst_n;
  bit          idling_on;
  int unsigned mismatches;
  int unsigned due_count;

  bfm_in_if  in_ch ();
  bfm_out_if out_ch ();
  bfm_cfg_if cfg_ch ();

  button_fan_mode_controller i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  fan_mode_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (mismatches),
    .due_count  (due_count)
  );

  always #1 clk = ~clk;

  // hold off the results for a long stretch now and then
  initial begin
    int unsigned taken;
    int unsigned hold_left;
    int unsigned next_hold;
    taken        = 0;
    hold_left    = 0;
    next_hold    = 200;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (taken >= next_hold) begin
        hold_left = RECEIVER_HOLD;
        next_hold += 40000;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idling_on && $urandom_range(99) < 14);
      end
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        taken++;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_tick(input logic pressed, input logic vbus, input logic chg);
    @(negedge clk);
    while (idling_on && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.switch_pressed    <= pressed;
    in_ch.vbus_present      <= vbus;
    in_ch.charge_status_pin <= chg;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bfm_pkg::CfgIdxW-1:0] idx,
                           input logic [bfm_pkg::CfgDataW-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] unit_ticks, input logic [7:0] long_units,
                                input logic [15:0] long_on, input logic [15:0] long_off,
                                input logic [15:0] short_on, input logic [15:0] short_off);
    drain_results();
    write_reg(bfm_pkg::CFG_PRESS_UNIT_TICKS, unit_ticks);
    write_reg(bfm_pkg::CFG_LONG_PRESS_UNITS, {8'd0, long_units});
    write_reg(bfm_pkg::CFG_LONG_ON_TICKS, long_on);
    write_reg(bfm_pkg::CFG_LONG_OFF_TICKS, long_off);
    write_reg(bfm_pkg::CFG_SHORT_ON_TICKS, short_on);
    write_reg(bfm_pkg::CFG_SHORT_OFF_TICKS, short_off);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly whole presses followed by a released wait, with some switch noise
  task automatic run_phase(input logic [15:0] unit_ticks, input logic [7:0] long_units,
                           input logic [15:0] long_on, input logic [15:0] long_off,
                           input logic [15:0] short_on, input logic [15:0] short_off,
                           input int hold_min, input int hold_max, input int wait_max,
                           input int budget, input bit idle_en);
    int sent;
    int n;
    apply_settings(unit_ticks, long_units, long_on, long_off, short_on, short_off);
    idling_on = idle_en;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 75) begin
        n = $urandom_range(hold_max, hold_min);
        repeat (n) send_tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent += n;
        n = $urandom_range(wait_max, 1);
        repeat (n) send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        n = $urandom_range(8, 1);
        repeat (n) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
      end
      sent += n;
    end
  endtask

  initial begin
    string       presses;
    int unsigned i;
    rst_n                   = 1'b0;
    idling_on               = 1'b1;
    in_ch.valid             = 1'b0;
    in_ch.switch_pressed    = 1'b0;
    in_ch.vbus_present      = 1'b0;
    in_ch.charge_status_pin = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = bfm_pkg::CFG_PRESS_UNIT_TICKS;
    cfg_ch.data             = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 4; i++) begin
      send_tick(1'b0, i[1], i[0]);
    end

    // release with nothing held, short press into start, presses ignored while
    // beeping, start handing over to low, then a long press back to standby
    apply_settings(16'd2, 8'd3, 16'd2, 16'd1, 16'd1, 16'd1);
    presses = "01101100111111000";
    for (i = 0; i < presses.len(); i++) begin
      send_tick(presses[i] == "1", 1'($urandom_range(1)), 1'($urandom_range(1)));
    end

    // long beep and long gap, from standby through start into low
    apply_settings(16'd1, 8'd1, 16'd40, 16'd1, 16'd1, 16'd40);
    send_tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
    send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat (90) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));

    run_phase(16'd1, 8'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1, 4, 12, 150, 1'b1);
    run_phase(16'd0, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0, 1, 6, 12, 150, 1'b1);
    run_phase(16'd1, 8'd255, 16'd2, 16'd1, 16'd1, 16'd2, 240, 300, 16, 250, 1'b1);
    run_phase(16'd3, 8'd4, 16'd5, 16'd2, 16'd3, 16'd2, 1, 24, 26, 150, 1'b1);
    run_phase(16'hFFFF, 8'd2, 16'd2, 16'd3, 16'd2, 16'd1, 1, 20, 18, 150, 1'b1);
    run_phase(16'd2, 8'd3, 16'd4, 16'd1, 16'd2, 16'd3, 1, 12, 24, 150, 1'b0);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/bfm_pkg.sv
design/bfm_if.sv
design/bfm_step.sv
design/button_fan_mode_controller.sv
sim/fan_mode_checker.sv
sim/testbench.sv
